// ===== rtl/eiec_pkg.sv =====
// ----------------------------------------------------------------------------
// eiec_pkg
// Shared types and constants of the external interrupt edge controller.
// ----------------------------------------------------------------------------
package eiec_pkg;

    // command codes of an input word
    typedef enum logic [1:0] {
        CMD_SAMPLE = 2'd0,
        CMD_CLEAR  = 2'd1,
        CMD_SWTRIG = 2'd2,
        CMD_NONE   = 2'd3
    } cmd_t;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_PORT_SEL = 2'd0,
        CFG_IRQ_MASK = 2'd1,
        CFG_RISE_EN  = 2'd2,
        CFG_FALL_EN  = 2'd3
    } cfg_idx_t;

    localparam int LINE_W      = 16;  // line vector width
    localparam int NIBBLE_BITS = 4;   // port select bits per line
    localparam int PORT_W      = 16;  // pins per port
    localparam int PINS_W      = 64;  // one pin word holds four ports
    localparam int SEL_W       = 64;  // port select register width
    localparam int CFG_W       = 64;  // config data width
    localparam int IRQ_W       = 7;   // request vector width
    localparam int PORT_LIMIT  = 8;   // ports carried by the two pin words

    typedef logic [LINE_W-1:0] line_vec_t;

endpackage

// ===== rtl/eiec_level_gather.sv =====
// ----------------------------------------------------------------------------
// eiec_level_gather
// Per-line port mux: picks each line's pin from the port named by its nibble.
// ----------------------------------------------------------------------------
module eiec_level_gather #(
    parameter int NUM_LINES = 16,
    parameter int NUM_PORTS = 8
) (
    input  logic [eiec_pkg::SEL_W-1:0]  port_sel,
    input  logic [eiec_pkg::PINS_W-1:0] pins_low,
    input  logic [eiec_pkg::PINS_W-1:0] pins_high,
    output eiec_pkg::line_vec_t         levels
);

    for (genvar i = 0; i < eiec_pkg::LINE_W; i++) begin : g_line
        logic [eiec_pkg::NIBBLE_BITS-1:0] p;
        logic [5:0]                       sh;
        logic                             port_ok;
        logic                             pin;

        assign p       = port_sel[eiec_pkg::NIBBLE_BITS*i +: eiec_pkg::NIBBLE_BITS];
        assign sh      = {p[1:0], 4'(i)};
        assign port_ok = ({1'b0, p} < 5'(NUM_PORTS)) && ({1'b0, p} < 5'(eiec_pkg::PORT_LIMIT));
        assign pin     = p[2] ? pins_high[sh] : pins_low[sh];

        if (i < NUM_LINES) begin : g_used
            assign levels[i] = port_ok & pin;
        end
        else begin : g_unused
            assign levels[i] = 1'b0;
        end
    end

endmodule

// ===== rtl/external_interrupt_edge_controller_unit.sv =====
// ----------------------------------------------------------------------------
// external_interrupt_edge_controller_unit
// Sixteen-line external interrupt controller with edge detect and soft trigger.
// ----------------------------------------------------------------------------
// Usage:
//   Input words (in_valid/in_ready) carry a command, two 64-bit pin words
//   (ports 0-3 and 4-7) and a line mask. Command sample compares the selected
//   pin of each line with its previous sample and sets pending on enabled
//   edges; clear drops pending and soft-trigger bits of the masked lines;
//   soft trigger sets trigger bits and, on unmasked lines not yet triggered,
//   pending. Each word yields one result word (out_valid/out_ready) with the
//   pending bits, the soft-trigger bits and seven request lines (two grouped).
//   An accepted word waits in the input register; the state and request
//   registers load from it when the output is free, then out_valid shows it.
//   Throughput: one word per cycle while the receiver takes results; the update
//   is one pass of logic from the input register into the state registers.
//   When the receiver stalls, the input register still takes one more word;
//   after that in_ready drops until the result is taken.
//   Reset clears the line state, request, config registers and both valid flags.
//   Config (cfg_wr_en/cfg_addr/cfg_wdata) is to be written by the user only while
//   no word is in flight; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module external_interrupt_edge_controller_unit #(
    parameter int NUM_LINES = 16,
    parameter int NUM_PORTS = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          cfg_wr_en,
    input  logic [1:0]                    cfg_addr,
    input  logic [eiec_pkg::CFG_W-1:0]    cfg_wdata,

    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [1:0]                    command,
    input  logic [eiec_pkg::PINS_W-1:0]   pin_levels_low,
    input  logic [eiec_pkg::PINS_W-1:0]   pin_levels_high,
    input  logic [eiec_pkg::LINE_W-1:0]   line_mask,

    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [eiec_pkg::LINE_W-1:0]   pending_flags,
    output logic [eiec_pkg::LINE_W-1:0]   soft_trigger_flags,
    output logic [eiec_pkg::IRQ_W-1:0]    irq_requests
);

    localparam eiec_pkg::line_vec_t LINES_ALL =
        eiec_pkg::LINE_W'((33'd1 << NUM_LINES) - 33'd1);

    // config registers
    logic [eiec_pkg::SEL_W-1:0] port_sel_reg;
    eiec_pkg::line_vec_t        irq_mask_reg;
    eiec_pkg::line_vec_t        rise_en_reg;
    eiec_pkg::line_vec_t        fall_en_reg;

    // input stage
    logic                        in_vld_reg;
    eiec_pkg::cmd_t              cmd_reg;
    logic [eiec_pkg::PINS_W-1:0] pins_lo_reg;
    logic [eiec_pkg::PINS_W-1:0] pins_hi_reg;
    eiec_pkg::line_vec_t         lmask_reg;

    // line state and result
    eiec_pkg::line_vec_t         prev_lvl_reg, prev_lvl_next;
    eiec_pkg::line_vec_t         pend_reg, pend_next;
    eiec_pkg::line_vec_t         swt_reg, swt_next;
    logic [eiec_pkg::IRQ_W-1:0]  irq_reg, irq_next;
    logic                        out_vld_reg;

    eiec_pkg::line_vec_t         cur_lvl;
    eiec_pkg::line_vec_t         lm;
    eiec_pkg::line_vec_t         req;
    logic                        advance;
    logic                        in_fire;

    assign advance  = in_vld_reg && (!out_vld_reg || out_ready);
    assign in_ready = !in_vld_reg || advance;
    assign in_fire  = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            port_sel_reg <= '0;
            irq_mask_reg <= '0;
            rise_en_reg  <= '0;
            fall_en_reg  <= '0;
        end
        else if (cfg_wr_en) begin
            case (eiec_pkg::cfg_idx_t'(cfg_addr))
                eiec_pkg::CFG_PORT_SEL: port_sel_reg <= cfg_wdata;
                eiec_pkg::CFG_IRQ_MASK: irq_mask_reg <= cfg_wdata[eiec_pkg::LINE_W-1:0];
                eiec_pkg::CFG_RISE_EN:  rise_en_reg  <= cfg_wdata[eiec_pkg::LINE_W-1:0];
                eiec_pkg::CFG_FALL_EN:  fall_en_reg  <= cfg_wdata[eiec_pkg::LINE_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            in_vld_reg <= 1'b0;
        end
        else if (in_ready) begin
            in_vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk) begin
        if (in_fire) begin
            cmd_reg     <= eiec_pkg::cmd_t'(command);
            pins_lo_reg <= pin_levels_low;
            pins_hi_reg <= pin_levels_high;
            lmask_reg   <= line_mask;
        end
    end

    eiec_level_gather #(
        .NUM_LINES (NUM_LINES),
        .NUM_PORTS (NUM_PORTS)
    ) u_gather (
        .port_sel  (port_sel_reg),
        .pins_low  (pins_lo_reg),
        .pins_high (pins_hi_reg),
        .levels    (cur_lvl)
    );

    assign lm = lmask_reg & LINES_ALL;

    always_comb begin
        prev_lvl_next = prev_lvl_reg;
        pend_next     = pend_reg;
        swt_next      = swt_reg;
        case (cmd_reg)
            eiec_pkg::CMD_SAMPLE: begin
                pend_next = (pend_reg
                             | (cur_lvl & ~prev_lvl_reg & rise_en_reg)
                             | (~cur_lvl & prev_lvl_reg & fall_en_reg)) & LINES_ALL;
                prev_lvl_next = cur_lvl;
            end
            eiec_pkg::CMD_CLEAR: begin
                pend_next = pend_reg & ~lm;
                swt_next  = swt_reg & ~lm;
            end
            eiec_pkg::CMD_SWTRIG: begin
                // pending only on lines whose trigger bit was still clear
                pend_next = (pend_reg | (lm & ~swt_reg & irq_mask_reg)) & LINES_ALL;
                swt_next  = (swt_reg | lm) & LINES_ALL;
            end
            default: ;
        endcase
        req      = pend_next & irq_mask_reg & LINES_ALL;
        irq_next = {|req[15:10], |req[9:5], req[4:0]};
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            prev_lvl_reg <= '0;
            pend_reg     <= '0;
            swt_reg      <= '0;
            irq_reg      <= '0;
            out_vld_reg  <= 1'b0;
        end
        else begin
            if (advance) begin
                prev_lvl_reg <= prev_lvl_next;
                pend_reg     <= pend_next;
                swt_reg      <= swt_next;
                irq_reg      <= irq_next;
            end
            if (advance) begin
                out_vld_reg <= 1'b1;
            end
            else if (out_ready) begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    // state only moves when the result word is loaded, so it is the result
    assign out_valid          = out_vld_reg;
    assign pending_flags      = pend_reg;
    assign soft_trigger_flags = swt_reg;
    assign irq_requests       = irq_reg;

endmodule

// ===== rtl/eiec_checker.sv =====
// ----------------------------------------------------------------------------
// eiec_checker
// Port-level checks of the external interrupt edge controller.
// ----------------------------------------------------------------------------
module eiec_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [eiec_pkg::LINE_W-1:0]   pending_flags,
    input logic [eiec_pkg::LINE_W-1:0]   soft_trigger_flags,
    input logic [eiec_pkg::IRQ_W-1:0]    irq_requests
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid
            && $stable(pending_flags) && $stable(soft_trigger_flags)
            && $stable(irq_requests))
        else $error("result word changed while stalled");

    // single-line requests need their pending bit
    a_irq_single: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (irq_requests[4:0] & ~pending_flags[4:0]) == 5'd0)
        else $error("request without pending bit");

    // grouped requests need a pending bit in their group
    a_irq_group: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (!irq_requests[5] || (|pending_flags[9:5]))
                   && (!irq_requests[6] || (|pending_flags[15:10])))
        else $error("group request without pending bit");

    // with the output free, the block keeps taking words
    a_no_block: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled while output empty");

endmodule

bind external_interrupt_edge_controller_unit eiec_checker u_eiec_checker (.*);

// ===== test/external_interrupt_edge_controller_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// external_interrupt_edge_controller_unit_tb
// Self-checking bench for the sixteen-line edge interrupt controller. A shadow
// copy of the line state predicts pending, soft-trigger and request vectors
// for every accepted word. Directed words cover the edge, clear, soft-trigger
// and port-select corners. Random words then run under several register
// settings with random gaps on both sides, a back-to-back burst and a long
// output stall.
// ----------------------------------------------------------------------------
module external_interrupt_edge_controller_unit_tb;

    typedef logic [eiec_pkg::CFG_W-1:0]       cfg_word_t;
    typedef logic [eiec_pkg::NIBBLE_BITS-1:0] nibble_t;

    typedef struct packed {
        eiec_pkg::line_vec_t          pending;
        eiec_pkg::line_vec_t          trig;
        logic [eiec_pkg::IRQ_W-1:0]   irq;
    } status_t;

    logic                           clk;
    logic                           rst_n;
    logic                           cfg_wr_en;
    logic [1:0]                     cfg_addr;
    logic [eiec_pkg::CFG_W-1:0]     cfg_wdata;
    logic                           in_valid;
    logic                           in_ready;
    logic [1:0]                     command;
    logic [eiec_pkg::PINS_W-1:0]    pin_levels_low;
    logic [eiec_pkg::PINS_W-1:0]    pin_levels_high;
    eiec_pkg::line_vec_t            line_mask;
    logic                           out_valid;
    logic                           out_ready;
    eiec_pkg::line_vec_t            pending_flags;
    eiec_pkg::line_vec_t            soft_trigger_flags;
    logic [eiec_pkg::IRQ_W-1:0]     irq_requests;

    // shadow of the controller
    logic [eiec_pkg::SEL_W-1:0]     sel_shadow;
    eiec_pkg::line_vec_t            mask_shadow;
    eiec_pkg::line_vec_t            rise_shadow;
    eiec_pkg::line_vec_t            fall_shadow;
    eiec_pkg::line_vec_t            level_shadow;
    eiec_pkg::line_vec_t            pend_shadow;
    eiec_pkg::line_vec_t            trig_shadow;

    status_t                        expected_status_q[$];
    logic [eiec_pkg::PINS_W-1:0]    last_lo;
    logic [eiec_pkg::PINS_W-1:0]    last_hi;
    bit                             steady;
    int                             stall_request;
    int                             errors;
    int                             words_sent;
    int                             results_checked;
    int                             settings_used;

    external_interrupt_edge_controller_unit dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_wr_en          (cfg_wr_en),
        .cfg_addr           (cfg_addr),
        .cfg_wdata          (cfg_wdata),
        .in_valid           (in_valid),
        .in_ready           (in_ready),
        .command            (command),
        .pin_levels_low     (pin_levels_low),
        .pin_levels_high    (pin_levels_high),
        .line_mask          (line_mask),
        .out_valid          (out_valid),
        .out_ready          (out_ready),
        .pending_flags      (pending_flags),
        .soft_trigger_flags (soft_trigger_flags),
        .irq_requests       (irq_requests)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("FAIL external_interrupt_edge_controller_unit");
        $finish;
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // level of each line from its selected port; nibbles 8..F have no port
    function automatic eiec_pkg::line_vec_t selected_levels(
        logic [eiec_pkg::PINS_W-1:0] lo, logic [eiec_pkg::PINS_W-1:0] hi);
        eiec_pkg::line_vec_t lv;
        nibble_t             port;
        lv = '0;
        for (int i = 0; i < eiec_pkg::LINE_W; i++)
        begin
            port = sel_shadow[eiec_pkg::NIBBLE_BITS*i +: eiec_pkg::NIBBLE_BITS];
            if (port < eiec_pkg::PORT_LIMIT)
                lv[i] = port[2] ? hi[eiec_pkg::PORT_W*port[1:0] + i]
                                : lo[eiec_pkg::PORT_W*port[1:0] + i];
        end
        return lv;
    endfunction

    function automatic void predict_status(eiec_pkg::cmd_t cmd,
                                           logic [eiec_pkg::PINS_W-1:0] lo,
                                           logic [eiec_pkg::PINS_W-1:0] hi,
                                           eiec_pkg::line_vec_t lm);
        eiec_pkg::line_vec_t cur;
        eiec_pkg::line_vec_t req;
        status_t             s;
        case (cmd)
            eiec_pkg::CMD_SAMPLE:
            begin
                cur = selected_levels(lo, hi);
                pend_shadow |= (cur & ~level_shadow & rise_shadow)
                             | (~cur & level_shadow & fall_shadow);
                level_shadow = cur;
            end
            eiec_pkg::CMD_CLEAR:
            begin
                pend_shadow &= ~lm;
                trig_shadow &= ~lm;
            end
            eiec_pkg::CMD_SWTRIG:
            begin
                // pending only where unmasked and not already triggered
                pend_shadow |= lm & ~trig_shadow & mask_shadow;
                trig_shadow |= lm;
            end
            default: ;
        endcase
        req       = pend_shadow & mask_shadow;
        s.pending = pend_shadow;
        s.trig    = trig_shadow;
        s.irq     = {|req[15:10], |req[9:5], req[4:0]};
        expected_status_q.push_back(s);
    endfunction

    task automatic check_result();
        status_t want;
        if (expected_status_q.size() == 0)
        begin
            $display("%0t: unexpected word, expected none, actual pending=%h trig=%h irq=%h",
                     $time, pending_flags, soft_trigger_flags, irq_requests);
            errors++;
        end
        else
        begin
            want = expected_status_q.pop_front();
            results_checked++;
            if (pending_flags !== want.pending)
            begin
                $display("%0t: pending_flags expected %h actual %h",
                         $time, want.pending, pending_flags);
                errors++;
            end
            if (soft_trigger_flags !== want.trig)
            begin
                $display("%0t: soft_trigger_flags expected %h actual %h",
                         $time, want.trig, soft_trigger_flags);
                errors++;
            end
            if (irq_requests !== want.irq)
            begin
                $display("%0t: irq_requests expected %h actual %h",
                         $time, want.irq, irq_requests);
                errors++;
            end
        end
    endtask

    // output side: checks each accepted word and stalls at random
    initial
    begin : result_checker
        int hold;
        hold = 0;
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
                check_result();
            if (stall_request > 0)
            begin
                hold = stall_request;
                stall_request = 0;
            end
            if (hold > 0)
            begin
                hold--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= steady || ($urandom_range(0, 99) >= 26);
        end
    end

    task automatic send_word(eiec_pkg::cmd_t cmd, logic [eiec_pkg::PINS_W-1:0] lo,
                             logic [eiec_pkg::PINS_W-1:0] hi, eiec_pkg::line_vec_t lm);
        while (!steady && $urandom_range(0, 99) < 26)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid        <= 1'b1;
        command         <= cmd;
        pin_levels_low  <= lo;
        pin_levels_high <= hi;
        line_mask       <= lm;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_status(cmd, lo, hi, lm);
        words_sent++;
    endtask

    // drain everything in flight, then allow for the two-stage pipeline
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_status_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic load_config(logic [eiec_pkg::SEL_W-1:0] sel, eiec_pkg::line_vec_t mask,
                               eiec_pkg::line_vec_t rise, eiec_pkg::line_vec_t fall);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= eiec_pkg::CFG_PORT_SEL;
        cfg_wdata <= sel;
        @(posedge clk);
        cfg_addr  <= eiec_pkg::CFG_IRQ_MASK;
        cfg_wdata <= cfg_word_t'(mask);
        @(posedge clk);
        cfg_addr  <= eiec_pkg::CFG_RISE_EN;
        cfg_wdata <= cfg_word_t'(rise);
        @(posedge clk);
        cfg_addr  <= eiec_pkg::CFG_FALL_EN;
        cfg_wdata <= cfg_word_t'(fall);
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        sel_shadow  = sel;
        mask_shadow = mask;
        rise_shadow = rise;
        fall_shadow = fall;
        settings_used++;
    endtask

    function automatic logic [eiec_pkg::SEL_W-1:0] random_port_select();
        logic [eiec_pkg::SEL_W-1:0] sel;
        for (int i = 0; i < eiec_pkg::LINE_W; i++)
            sel[eiec_pkg::NIBBLE_BITS*i +: eiec_pkg::NIBBLE_BITS] =
                nibble_t'(($urandom_range(0, 9) < 8) ?
                          $urandom_range(0, 7) : $urandom_range(8, 15));
        return sel;
    endfunction

    function automatic eiec_pkg::line_vec_t random_lines();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            default: return eiec_pkg::line_vec_t'($urandom);
        endcase
    endfunction

    task automatic send_random_word();
        int             pick;
        eiec_pkg::cmd_t cmd;
        pick = $urandom_range(0, 99);
        if (pick < 60)
            cmd = eiec_pkg::CMD_SAMPLE;
        else if (pick < 75)
            cmd = eiec_pkg::CMD_CLEAR;
        else if (pick < 92)
            cmd = eiec_pkg::CMD_SWTRIG;
        else
            cmd = eiec_pkg::CMD_NONE;
        // pins: hold, replace, or flip a few bits so edges stay sparse at times
        case ($urandom_range(0, 3))
            0: ;
            1:
            begin
                last_lo = rand64();
                last_hi = rand64();
            end
            default:
            begin
                last_lo ^= rand64() & rand64() & rand64();
                last_hi ^= rand64() & rand64() & rand64();
            end
        endcase
        send_word(cmd, last_lo, last_hi, random_lines());
    endtask

    task automatic test_directed();
        // every line on port 0, all edges and requests enabled
        load_config('0, '1, '1, '1);
        send_word(eiec_pkg::CMD_SAMPLE, '0, '0, '0);
        send_word(eiec_pkg::CMD_SAMPLE, '1, '0, '0);
        send_word(eiec_pkg::CMD_SAMPLE, '0, '1, '1);
        send_word(eiec_pkg::CMD_CLEAR,  '0, '0, '1);
        send_word(eiec_pkg::CMD_SAMPLE, '1, '1, '0);
        send_word(eiec_pkg::CMD_CLEAR,  '1, '1, 16'h00FF);
        send_word(eiec_pkg::CMD_SWTRIG, '1, '1, '1);
        send_word(eiec_pkg::CMD_SWTRIG, '1, '1, 16'h0F0F);
        send_word(eiec_pkg::CMD_NONE,   '0, '0, '1);
        send_word(eiec_pkg::CMD_CLEAR,  '1, '1, '1);
        wait_idle();
        // line i on port i; lines 8..15 select no port and read low
        load_config(64'hFEDC_BA98_7654_3210, 16'h00FF, 16'hAAAA, 16'h5555);
        send_word(eiec_pkg::CMD_SAMPLE, '1, '1, '0);
        send_word(eiec_pkg::CMD_SAMPLE, '0, '1, '0);
        send_word(eiec_pkg::CMD_SAMPLE, '1, '0, '0);
        send_word(eiec_pkg::CMD_SWTRIG, '0, '0, '1);
        send_word(eiec_pkg::CMD_CLEAR,  '0, '0, 16'h0001);
        wait_idle();
        // lines 0..7 with no port, lines 8..15 on ports 0..7; only line 0 may
        // pend on the soft trigger since the others are still triggered
        load_config(64'h7654_3210_FEDC_BA98, '1, '1, '0);
        send_word(eiec_pkg::CMD_SWTRIG, '0, '0, '1);
        send_word(eiec_pkg::CMD_SAMPLE, '1, '1, '0);
        send_word(eiec_pkg::CMD_SAMPLE, '0, '0, '0);
        send_word(eiec_pkg::CMD_CLEAR,  '0, '0, '1);
        send_word(eiec_pkg::CMD_SAMPLE, '1, '1, '0);
        wait_idle();
    endtask

    task automatic test_random_settings();
        for (int phase = 0; phase < 8; phase++)
        begin
            case (phase)
                0:       load_config('0, '0, '0, '0);
                1:       load_config('1, '1, '1, '1);
                2:       load_config(64'h7777_7777_7777_7777, '1, '1, '1);
                default: load_config(random_port_select(), random_lines(),
                                     random_lines(), random_lines());
            endcase
            repeat (75) send_random_word();
            wait_idle();
        end
    endtask

    task automatic test_back_to_back();
        load_config(random_port_select(), '1, eiec_pkg::line_vec_t'($urandom),
                    eiec_pkg::line_vec_t'($urandom));
        steady = 1'b1;
        repeat (100) send_random_word();
        steady = 1'b0;
        wait_idle();
    endtask

    // long output stall with the input kept busy so in_ready must drop
    task automatic test_output_stall();
        load_config(random_port_select(), eiec_pkg::line_vec_t'($urandom), '1, '1);
        steady        = 1'b1;
        stall_request = 60;
        repeat (30) send_random_word();
        steady = 1'b0;
        wait_idle();
    endtask

    initial
    begin
        rst_n           = 1'b0;
        cfg_wr_en       = 1'b0;
        cfg_addr        = eiec_pkg::CFG_PORT_SEL;
        cfg_wdata       = '0;
        in_valid        = 1'b0;
        command         = eiec_pkg::CMD_NONE;
        pin_levels_low  = '0;
        pin_levels_high = '0;
        line_mask       = '0;
        out_ready       = 1'b0;
        sel_shadow      = '0;
        mask_shadow     = '0;
        rise_shadow     = '0;
        fall_shadow     = '0;
        level_shadow    = '0;
        pend_shadow     = '0;
        trig_shadow     = '0;
        last_lo         = '0;
        last_hi         = '0;
        steady          = 1'b0;
        stall_request   = 0;
        errors          = 0;
        words_sent      = 0;
        results_checked = 0;
        settings_used   = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_random_settings();
        test_back_to_back();
        test_output_stall();
        wait_idle();

        $display("Sent %0d words (sample, clear, soft trigger, unused code) over %0d settings",
                 words_sent, settings_used);
        $display("Checked %0d status words, including a back-to-back burst and a long stall",
                 results_checked);
        if (errors == 0)
            $display("PASS external_interrupt_edge_controller_unit");
        else
            $display("FAIL external_interrupt_edge_controller_unit");
        $finish;
    end

endmodule
